@@ design/mhi_pkg.sv @@
// ----------------------------------------------------------------------------
// mhi_pkg
// Shared sizes and controller/datapath handshake structs for the max-heap
// insert block.
// ----------------------------------------------------------------------------
package mhi_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 10;
    localparam int COUNT_W  = 11;
    localparam int SLOT_W   = 10;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = KEY_W + TAG_W;

    typedef struct packed {
        logic load;         // take in a new word
        logic rd_from_pos;  // fetch parent of the current slot
        logic rd_from_par;  // fetch parent of the last fetched parent
        logic swap;         // move fetched parent down into the current slot
        logic place;        // write the new entry at the current slot
        logic emit;         // load the result register
    } mhi_cmd_t;

    typedef struct packed {
        logic full;         // heap holds CAPACITY entries
        logic pos_zero;     // current slot is the root
        logic par_zero;     // last fetched parent is the root
        logic less;         // fetched parent key is below the new key
        logic out_free;     // result register can take a word
    } mhi_sts_t;

endpackage

@@ design/max_heap_insert.sv @@
// ----------------------------------------------------------------------------
// max_heap_insert
// Binary max-heap insert with tagged entries and a per-insert status word.
// ----------------------------------------------------------------------------
// One word is taken at a time. Unless its slot is the root, an insert first
// fetches the parent of that slot, then compares one parent at a time, as the
// heap memory has a single read port, moving each smaller parent down; it
// then places the entry and loads the result. A word for a full heap goes
// straight to the result. No result is loaded while an earlier one still
// waits on m_ready. The next word is accepted as soon as the result is
// loaded, even while that result waits on m_ready.
// ----------------------------------------------------------------------------
module max_heap_insert (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [mhi_pkg::KEY_W-1:0]   s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mhi_pkg::KEY_W-1:0]   m_top_value,
    output logic        [mhi_pkg::TAG_W-1:0]   m_top_tag,
    output logic        [mhi_pkg::COUNT_W-1:0] m_count,
    output logic        [mhi_pkg::SLOT_W-1:0]  m_slot,
    output logic                               m_accepted
);
    import mhi_pkg::*;

    mhi_cmd_t cmd;
    mhi_sts_t sts;

    mhi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mhi_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_top_tag   (m_top_tag),
        .m_count     (m_count),
        .m_slot      (m_slot),
        .m_accepted  (m_accepted)
    );

endmodule

@@ design/mhi_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhi_ctrl
// Sequencer for one insert: load, sift up one level per cycle, place, report; a full heap skips to report.
// ----------------------------------------------------------------------------
module mhi_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mhi_pkg::mhi_sts_t sts,
    output mhi_pkg::mhi_cmd_t cmd
);
    import mhi_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CHECK   = 3'd1;
    localparam logic [2:0] ST_COMPARE = 3'd2;
    localparam logic [2:0] ST_PLACE   = 3'd3;
    localparam logic [2:0] ST_RESULT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.full ? ST_RESULT : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.pos_zero) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.rd_from_pos = 1'b1;
                    state_next      = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                if (sts.less) begin
                    cmd.swap = 1'b1;
                    // fetch the next level while the parent moves down
                    if (sts.par_zero) begin
                        state_next = ST_PLACE;
                    end else begin
                        cmd.rd_from_par = 1'b1;
                    end
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                cmd.place  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/mhi_dp.sv @@
// ----------------------------------------------------------------------------
// mhi_dp
// Heap storage, sift-up registers, fill/tag counters and the result register.
// ----------------------------------------------------------------------------
module mhi_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mhi_pkg::mhi_cmd_t                  cmd,
    output mhi_pkg::mhi_sts_t                  sts,
    input  logic signed [mhi_pkg::KEY_W-1:0]   s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mhi_pkg::KEY_W-1:0]   m_top_value,
    output logic        [mhi_pkg::TAG_W-1:0]   m_top_tag,
    output logic        [mhi_pkg::COUNT_W-1:0] m_count,
    output logic        [mhi_pkg::SLOT_W-1:0]  m_slot,
    output logic                               m_accepted
);
    import mhi_pkg::*;

    logic [ENTRY_W-1:0] mem [CAPACITY];

    logic signed [KEY_W-1:0] key_reg;
    logic [IDX_W-1:0]        pos_reg;
    logic [IDX_W-1:0]        par_reg;
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic                    ok_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [TAG_W-1:0]        insert_reg;
    logic signed [KEY_W-1:0] root_key_reg;
    logic [TAG_W-1:0]        root_tag_reg;

    logic                    m_valid_reg;
    logic signed [KEY_W-1:0] top_value_reg;
    logic [TAG_W-1:0]        top_tag_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic                    accepted_reg;

    logic [IDX_W-1:0]        rd_src;
    logic [IDX_W-1:0]        rd_addr;
    logic                    rd_en;
    logic                    we;
    logic [IDX_W-1:0]        wr_addr;
    logic [ENTRY_W-1:0]      wr_data;
    logic signed [KEY_W-1:0] par_key;
    logic [IDX_W+SLOT_W-1:0]   slot_ext;
    logic [FILL_W+COUNT_W-1:0] count_ext;

    assign rd_src  = cmd.rd_from_par ? par_reg : pos_reg;
    assign rd_addr = (rd_src - IDX_W'(1)) >> 1;
    assign rd_en   = cmd.rd_from_pos | cmd.rd_from_par;
    assign par_key = rd_data_reg[ENTRY_W-1:TAG_W];

    assign we      = cmd.swap | cmd.place;
    assign wr_addr = pos_reg;
    assign wr_data = cmd.place ? {key_reg, insert_reg} : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // sift-up working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= s_value;
            pos_reg <= fill_reg[IDX_W-1:0];
            ok_reg  <= (fill_reg != FILL_W'(CAPACITY));
        end else if (cmd.swap) begin
            pos_reg <= par_reg;
        end
        if (rd_en) begin
            par_reg <= rd_addr;
        end
        if (cmd.place && pos_reg == '0) begin
            root_key_reg <= key_reg;
            root_tag_reg <= insert_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            insert_reg <= '0;
        end else if (cmd.place) begin
            fill_reg   <= fill_reg + FILL_W'(1);
            insert_reg <= insert_reg + TAG_W'(1);
        end
    end

    assign slot_ext  = {{SLOT_W{1'b0}}, (ok_reg ? pos_reg : IDX_W'(0))};
    assign count_ext = {{COUNT_W{1'b0}}, fill_reg};

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            top_value_reg <= root_key_reg;
            top_tag_reg   <= root_tag_reg;
            count_reg     <= count_ext[COUNT_W-1:0];
            slot_reg      <= slot_ext[SLOT_W-1:0];
            accepted_reg  <= ok_reg;
        end
    end

    always_comb begin
        sts.full     = (fill_reg == FILL_W'(CAPACITY));
        sts.pos_zero = (pos_reg == '0);
        sts.par_zero = (par_reg == '0);
        sts.less     = (par_key < key_reg);
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid     = m_valid_reg;
    assign m_top_value = top_value_reg;
    assign m_top_tag   = top_tag_reg;
    assign m_count     = count_reg;
    assign m_slot      = slot_reg;
    assign m_accepted  = accepted_reg;

endmodule

@@ design/mhi_checker.sv @@
// ----------------------------------------------------------------------------
// mhi_checker
// Port-level checks on the max-heap insert result channel.
// ----------------------------------------------------------------------------
module mhi_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [mhi_pkg::KEY_W-1:0]   m_top_value,
    input logic        [mhi_pkg::COUNT_W-1:0] m_count,
    input logic        [mhi_pkg::SLOT_W-1:0]  m_slot,
    input logic                               m_accepted
);
    import mhi_pkg::*;

    // a stalled word holds
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped while stalled");

    a_hold_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_top_value))
        else $error("m_top_value changed while stalled");

    // a dropped word reports the root slot
    a_drop_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |-> m_slot == '0)
        else $error("dropped word reports nonzero slot");

    // an accepted entry in a heap of at most one entry sits at the root slot
    a_slot_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted && m_count <= COUNT_W'(1) |-> m_slot == '0)
        else $error("slot outside a single-entry heap");

endmodule

bind max_heap_insert mhi_checker u_mhi_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_top_value (m_top_value),
    .m_count     (m_count),
    .m_slot      (m_slot),
    .m_accepted  (m_accepted)
);
